// ----- hw/rtl/looped_wavetable_interpolator_macros.svh -----
// assertion macros for the looped wavetable interpolator
`ifndef LOOPED_WAVETABLE_INTERPOLATOR_MACROS_SVH
`define LOOPED_WAVETABLE_INTERPOLATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define LWI_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LWI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LWI_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define LWI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/lwi_pkg.sv -----
// shared constants and types for the looped wavetable interpolator
package lwi_pkg;

    // default sample memory address width
    localparam int ADDR_BITS_DEFAULT = 16;

    // request kinds
    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_START  = 2'd1;
    localparam logic [1:0] REQ_RENDER = 2'd2;

    // loop modes
    localparam logic [1:0] LOOP_NONE          = 2'd0;
    localparam logic [1:0] LOOP_ALWAYS        = 2'd1;
    localparam logic [1:0] LOOP_UNTIL_RELEASE = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_INDEX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYBACK_RATE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CURSOR  = 3'd6;

    // reset value of the playback rate (1.0 in 4.16)
    localparam logic [19:0] RATE_RESET = 20'h10000;

    // largest cursor step, just under 16 samples
    localparam logic [19:0] STEP_MAX = 20'hFFFFF;

    // output queue depth
    localparam int OUT_DEPTH = 8;

    // one queued result word
    typedef struct packed {
        logic        finished;
        logic [15:0] sample;
    } out_word_t;

endpackage

// ----- hw/rtl/looped_wavetable_interpolator.sv -----
// looped wavetable interpolator: one sample-playback voice with linear interpolation
// a render word passes the stage 1, stage 2 and stage 3 registers and then the output queue
// throughput: one word per cycle while credits are free; the cursor update loop sets the rate
// the sample memory has one write port and two read ports (floor and ceiling sample)
// an 8-word output queue with credit count keeps input and output apart
// reset clears cursor, finished flag and queue, resets config registers; sample memory is kept
`include "looped_wavetable_interpolator_macros.svh"

module looped_wavetable_interpolator #(
    parameter int ADDR_BITS = lwi_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [lwi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data,
    // request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // address[15:0], sample_value[31:16], in_release[32], tuning_ratio[48:33], zero[55:49]
    input  logic [55:0]                    s_tdata,
    // req_type[1:0]
    input  logic [1:0]                     s_tuser,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // sample_out[15:0]
    output logic [15:0]                    m_tdata,
    // finished[0]
    output logic                           m_tuser
);

    localparam int DEPTH     = 1 << ADDR_BITS;
    localparam int OUT_PTR_W = $clog2(lwi_pkg::OUT_DEPTH);

    // configuration registers
    logic [15:0] loop_start_reg;
    logic [15:0] loop_end_reg;
    logic [15:0] end_index_reg;
    logic [16:0] sample_length_reg;
    logic [1:0]  loop_mode_reg;
    logic [19:0] playback_rate_reg;
    logic [31:0] start_cursor_reg;

    // voice state
    logic [31:0] cursor_reg;
    logic [31:0] cursor_next;
    logic        done_reg;
    logic        done_next;

    // sample memory
    logic [15:0] sample_mem [0:DEPTH-1];
    logic [15:0] mem_lo_reg;
    logic [15:0] mem_hi_reg;

    // stage 1 registers
    logic        s1_valid_reg;
    logic [1:0]  s1_req_reg;
    logic [15:0] s1_addr_reg;
    logic [15:0] s1_value_reg;
    logic        s1_release_reg;
    logic [19:0] s1_step_reg;

    // stage 2 registers
    logic        s2_valid_reg;
    logic        s2_silent_reg;
    logic [15:0] s2_frac_reg;

    // stage 3 registers
    logic               s3_valid_reg;
    logic               s3_silent_reg;
    logic [15:0]        s3_lo_reg;
    logic signed [33:0] s3_prod_reg;

    // output queue
    lwi_pkg::out_word_t        fifo_mem [0:lwi_pkg::OUT_DEPTH-1];
    logic [OUT_PTR_W-1:0]      wr_ptr_reg;
    logic [OUT_PTR_W-1:0]      rd_ptr_reg;
    logic [OUT_PTR_W:0]        fifo_cnt_reg;
    logic [OUT_PTR_W:0]        used_reg;
    logic [OUT_PTR_W:0]        used_next;

    // handshake
    logic in_accept;
    logic in_render;
    logic out_pop;
    logic out_push;

    assign s_tready  = (used_reg < (OUT_PTR_W+1)'(lwi_pkg::OUT_DEPTH));
    assign in_accept = s_tvalid && s_tready;
    assign in_render = in_accept && (s_tuser == lwi_pkg::REQ_RENDER);
    assign m_tvalid  = (fifo_cnt_reg != '0);
    assign out_pop   = m_tvalid && m_tready;
    assign out_push  = s3_valid_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_start_reg    <= '0;
            loop_end_reg      <= '0;
            end_index_reg     <= '0;
            sample_length_reg <= '0;
            loop_mode_reg     <= lwi_pkg::LOOP_NONE;
            playback_rate_reg <= lwi_pkg::RATE_RESET;
            start_cursor_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                lwi_pkg::CFG_LOOP_START:    loop_start_reg    <= cfg_data[15:0];
                lwi_pkg::CFG_LOOP_END:      loop_end_reg      <= cfg_data[15:0];
                lwi_pkg::CFG_END_INDEX:     end_index_reg     <= cfg_data[15:0];
                lwi_pkg::CFG_SAMPLE_LENGTH: sample_length_reg <= cfg_data[16:0];
                lwi_pkg::CFG_LOOP_MODE:     loop_mode_reg     <= cfg_data[1:0];
                lwi_pkg::CFG_PLAYBACK_RATE: playback_rate_reg <= cfg_data[19:0];
                lwi_pkg::CFG_START_CURSOR:  start_cursor_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // cursor step: rate times tuning, saturated
    logic [35:0] rate_prod;
    logic [19:0] step_in;

    always_comb
    begin
        rate_prod = {16'h0, playback_rate_reg} * {20'h0, s_tdata[48:33]};
        step_in   = (|rate_prod[35:34]) ? lwi_pkg::STEP_MAX : rate_prod[33:14];
    end

    // stage 1 capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_req_reg     <= s_tuser;
            s1_addr_reg    <= s_tdata[15:0];
            s1_value_reg   <= s_tdata[31:16];
            s1_release_reg <= s_tdata[32];
            s1_step_reg    <= step_in;
        end
    end

    // stage 1: loop wrap, end clamp, read addresses, cursor advance
    logic        s1_render;
    logic        s1_write;
    logic        s1_start;
    logic        looped;
    logic        loop_ok;
    logic        wrap_cur;
    logic        wrap_ceil;
    logic        finish_now;
    logic [15:0] loop_len;
    logic [15:0] end_eff;
    logic [15:0] floor_idx;
    logic [16:0] ceil_raw;
    logic [16:0] ceil_idx;
    logic [31:0] cur_eff;
    logic [32:0] cur_sum;

    always_comb
    begin
        s1_render  = s1_valid_reg && (s1_req_reg == lwi_pkg::REQ_RENDER);
        s1_write   = s1_valid_reg && (s1_req_reg == lwi_pkg::REQ_WRITE);
        s1_start   = s1_valid_reg && (s1_req_reg == lwi_pkg::REQ_START);
        loop_len   = loop_end_reg - loop_start_reg;
        loop_ok    = (loop_end_reg > loop_start_reg);
        looped     = (loop_mode_reg == lwi_pkg::LOOP_ALWAYS)
                  || ((loop_mode_reg == lwi_pkg::LOOP_UNTIL_RELEASE) && !s1_release_reg);
        wrap_cur   = looped && loop_ok && (cursor_reg[31:16] >= loop_end_reg);
        cur_eff    = wrap_cur ? (cursor_reg - {loop_len, 16'h0}) : cursor_reg;
        floor_idx  = cur_eff[31:16];
        ceil_raw   = {1'b0, floor_idx} + 17'd1;
        wrap_ceil  = looped && loop_ok && (ceil_raw >= {1'b0, loop_end_reg});
        ceil_idx   = wrap_ceil ? (ceil_raw - {1'b0, loop_len}) : ceil_raw;
        if ({1'b0, end_index_reg} >= sample_length_reg)
        begin
            end_eff = (sample_length_reg == '0) ? 16'h0 : 16'(sample_length_reg - 17'd1);
        end
        else
        begin
            end_eff = end_index_reg;
        end
        finish_now = !looped && (ceil_raw >= {1'b0, end_eff});
        cur_sum    = {1'b0, cur_eff} + {13'h0, s1_step_reg};

        cursor_next = cursor_reg;
        done_next   = done_reg;
        if (s1_start)
        begin
            cursor_next = start_cursor_reg;
            done_next   = 1'b0;
        end
        else if (s1_render && !done_reg)
        begin
            if (finish_now)
            begin
                done_next = 1'b1;
            end
            else
            begin
                cursor_next = cur_sum[32] ? 32'hFFFF_FFFF : cur_sum[31:0];
            end
        end
    end

    // voice state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            done_reg   <= done_next;
        end
    end

    // sample memory write port
    always_ff @(posedge clk)
    begin
        if (s1_write)
        begin
            sample_mem[ADDR_BITS'(s1_addr_reg)] <= s1_value_reg;
        end
    end

    // sample memory read ports, floor and ceiling
    always_ff @(posedge clk)
    begin
        if (s1_render)
        begin
            mem_lo_reg <= sample_mem[ADDR_BITS'(floor_idx)];
            mem_hi_reg <= sample_mem[ADDR_BITS'(ceil_idx)];
        end
    end

    // stage 2 capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_render;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_render)
        begin
            s2_silent_reg <= done_reg || finish_now;
            s2_frac_reg   <= cur_eff[15:0];
        end
    end

    // stage 2: slope times fraction
    logic signed [16:0] diff;
    logic signed [33:0] slope_prod;

    always_comb
    begin
        diff       = {mem_hi_reg[15], mem_hi_reg} - {mem_lo_reg[15], mem_lo_reg};
        slope_prod = diff * $signed({1'b0, s2_frac_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_silent_reg <= s2_silent_reg;
            s3_lo_reg     <= mem_lo_reg;
            s3_prod_reg   <= slope_prod;
        end
    end

    // stage 3: add base sample, round half up
    logic [33:0]        interp_acc;
    lwi_pkg::out_word_t push_word;

    always_comb
    begin
        interp_acc = {{2{s3_lo_reg[15]}}, s3_lo_reg, 16'h0} + s3_prod_reg + 34'h8000;
        push_word.finished = s3_silent_reg;
        push_word.sample   = s3_silent_reg ? 16'h0 : interp_acc[31:16];
    end

    // output queue storage
    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            fifo_mem[wr_ptr_reg] <= push_word;
        end
    end

    // credit count covers words in flight and queued
    always_comb
    begin
        used_next = used_reg;
        if (in_render && !out_pop)
        begin
            used_next = used_reg + 1'b1;
        end
        else if (!in_render && out_pop)
        begin
            used_next = used_reg - 1'b1;
        end
    end

    // output queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            used_reg     <= '0;
        end
        else
        begin
            used_reg <= used_next;
            if (out_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (out_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (out_push && !out_pop)
            begin
                fifo_cnt_reg <= fifo_cnt_reg + 1'b1;
            end
            else if (!out_push && out_pop)
            begin
                fifo_cnt_reg <= fifo_cnt_reg - 1'b1;
            end
        end
    end

    assign m_tdata = fifo_mem[rd_ptr_reg].sample;
    assign m_tuser = fifo_mem[rd_ptr_reg].finished;

    // checks
    `LWI_ASSERT_IMPLIES(a_credit_bound, clk, rst_n, 1'b1, (fifo_cnt_reg <= used_reg) && (used_reg <= (OUT_PTR_W+1)'(lwi_pkg::OUT_DEPTH)), "credit count out of range")
    `LWI_ASSERT_IMPLIES(a_no_overflow, clk, rst_n, out_push && !out_pop, fifo_cnt_reg < (OUT_PTR_W+1)'(lwi_pkg::OUT_DEPTH), "output queue overflow")
    `LWI_ASSERT_IMPLIES(a_finished_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata == 16'h0, "finished word carries nonzero sample")
    `LWI_ASSERT_NEXT(a_done_holds, clk, rst_n, done_reg && !s1_start, done_reg && $stable(cursor_reg), "finished voice changed without start")

endmodule
